@@ design/tjts_pkg.sv @@
// Shared types and constants for the teleop joint target supervisor.
// Used by the controller, the datapath and the top level; no dependencies.
package tjts_pkg;

  localparam logic [1:0] KIND_COMMAND = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RESULT  = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  localparam logic [1:0] MODE_WAIT   = 2'd0;
  localparam logic [1:0] MODE_ACTIVE = 2'd1;
  localparam logic [1:0] MODE_HOLD   = 2'd2;
  localparam logic [1:0] MODE_FAULT  = 2'd3;

  localparam logic [2:0] REJ_NONE      = 3'd0;
  localparam logic [2:0] REJ_BAD       = 3'd1;
  localparam logic [2:0] REJ_BUS       = 3'd2;
  localparam logic [2:0] REJ_STALE     = 3'd3;
  localparam logic [2:0] REJ_HANDSHAKE = 3'd4;

  localparam logic [2:0] REG_TOLERANCE = 3'd0;
  localparam logic [2:0] REG_TIMEOUT   = 3'd1;
  localparam logic [2:0] REG_VEL0      = 3'd2;

  localparam int          VEL_REGS      = 6;
  localparam logic [14:0] TOL_RESET     = 15'd410;
  localparam logic [15:0] TIMEOUT_RESET = 16'd250;
  localparam logic [15:0] VEL_RESET     = 16'd8192;

  localparam logic [5:0] DT_FIRST = 6'd20;
  localparam logic [5:0] DT_MIN   = 6'd1;
  localparam logic [5:0] DT_MAX   = 6'd50;

  // floor(p / 1000) = (p * ceil(2^32 / 1000)) >> 32, exact for p below 2^22.
  localparam logic [22:0] DIV_RECIP = 23'd4294968;
  localparam int          DIV_SHIFT = 32;

  typedef struct packed {
    logic stage;
    logic latch;
    logic scan;
    logic decide;
    logic mul;
    logic div;
    logic step;
    logic fin;
    logic first;
  } ctl_cmd_t;

  typedef struct packed {
    logic move;
  } dp_status_t;

endpackage

@@ design/tjts_ctrl.sv @@
// Sequencer for the supervisor: request handshakes, joint walk and phases.
// Depends on tjts_pkg; drives tjts_datapath through ctl_cmd_t.
module tjts_ctrl #(
  parameter int JOINTS = 6,
  parameter int JW = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  s_tlast,
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic                  m_tlast,
  input  tjts_pkg::dp_status_t  status,
  output tjts_pkg::ctl_cmd_t    cmd,
  output logic [JW-1:0]         jcnt
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_STEP   = 8'b0010_0000,
    S_FIN    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  localparam logic [JW-1:0] JLAST = JW'(JOINTS - 1);

  state_t state, state_next;
  logic [JW-1:0] jcnt_next;
  logic accept, live;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tlast  = (jcnt == JLAST);
  assign accept   = s_tvalid && s_tready;
  assign live     = accept && (s_tuser != tjts_pkg::KIND_UNUSED);

  always_comb begin
    cmd        = '0;
    cmd.stage  = live;
    cmd.latch  = live && s_tlast;
    cmd.scan   = (state == S_SCAN);
    cmd.decide = (state == S_DECIDE);
    cmd.mul    = (state == S_MUL);
    cmd.div    = (state == S_DIV);
    cmd.step   = (state == S_STEP);
    cmd.fin    = (state == S_FIN);
    cmd.first  = (jcnt == '0);
  end

  always_comb begin
    state_next = state;
    jcnt_next  = jcnt;
    unique case (state)
      S_IDLE: begin
        if (live && s_tlast) begin
          state_next = S_SCAN;
          jcnt_next  = '0;
        end
      end
      S_SCAN: begin
        if (jcnt == JLAST) begin
          state_next = S_DECIDE;
          jcnt_next  = '0;
        end else begin
          jcnt_next = jcnt + 1'b1;
        end
      end
      S_DECIDE: state_next = status.move ? S_MUL : S_OUT;
      S_MUL:    state_next = S_DIV;
      S_DIV:    state_next = S_STEP;
      S_STEP: begin
        if (jcnt == JLAST) begin
          state_next = S_FIN;
          jcnt_next  = '0;
        end else begin
          state_next = S_MUL;
          jcnt_next  = jcnt + 1'b1;
        end
      end
      S_FIN: state_next = S_OUT;
      S_OUT: begin
        if (m_tready) begin
          if (jcnt == JLAST) begin
            state_next = S_IDLE;
            jcnt_next  = '0;
          end else begin
            jcnt_next = jcnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
        jcnt_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      jcnt  <= '0;
    end else begin
      state <= state_next;
      jcnt  <= jcnt_next;
    end
  end

endmodule

@@ design/tjts_datapath.sv @@
// Supervisor state, staging, configuration, decision logic and joint motion.
// Depends on tjts_pkg; sequenced by tjts_ctrl.
module tjts_datapath #(
  parameter int JOINTS = 6,
  parameter int ANGLE_BITS = 16,
  parameter int JW = 3,
  parameter int IW = 136,
  parameter int OW = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tjts_pkg::ctl_cmd_t   cmd,
  input  logic [JW-1:0]        jcnt,
  output tjts_pkg::dp_status_t status,
  input  logic [1:0]           kind,
  input  logic [IW-1:0]        in_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output logic [OW-1:0]        out_data
);

  localparam int A      = ANGLE_BITS;
  localparam int TG_LO  = 3;
  localparam int ME_LO  = 3 + A;
  localparam int BAD_B  = 3 + 2 * A;
  localparam int SES_LO = 4 + 2 * A;
  localparam int SEQ_LO = 36 + 2 * A;
  localparam int TIM_LO = 68 + 2 * A;
  localparam int BUS_B  = 100 + 2 * A;
  localparam int WOK_B  = 101 + 2 * A;
  localparam int CW     = (A + 1 > 15) ? A + 1 : 15;
  localparam int LW     = (A + 2 > 14) ? A + 2 : 14;

  logic [14:0] tol;
  logic [15:0] timeout;
  logic [15:0] vel [tjts_pkg::VEL_REGS];

  logic [1:0]  mode;
  logic [31:0] session, recv_seq, applied_seq, last_cmd_time, arm_seq, final_seq;
  logic [31:0] last_tick_time;
  logic        have_seq, arm_pending, final_pending, have_tick, staged_bad;
  logic signed [A-1:0] desired [JOINTS];
  logic signed [A-1:0] applied [JOINTS];
  logic signed [A-1:0] stg_t [JOINTS];
  logic signed [A-1:0] stg_m [JOINTS];

  logic [1:0]  ev_kind;
  logic [31:0] ev_sess, ev_seq, ev_now;
  logic        ev_bus, ev_wok, ev_bad;

  logic [2:0]  rej;
  logic        arm, wr, fin, near_tm, near_ta;
  logic [31:0] wseq;
  logic [5:0]  dt;
  logic [21:0] prod;
  logic [12:0] lim;

  logic [2:0]  ji;
  logic [JW-1:0] jw;

  logic [1:0]  mode_next;
  logic [31:0] session_next, recv_next, applied_seq_next, lct_next;
  logic [31:0] arm_seq_next, final_seq_next, wseq_next, d32;
  logic        have_seq_next, arm_p_next, final_p_next, arm_next, move_next;
  logic        load_meas, load_tgt, hold_now, tick_upd;
  logic [2:0]  rej_next;
  logic [5:0]  dt_next;

  logic signed [A:0]    d_tm, d_ta, diff, rem;
  logic signed [LW-1:0] diffx, limx, stepx;
  logic signed [A:0]    step;
  logic signed [A:0]    sum;
  logic [44:0]          qf;

  function automatic logic near_ok(input logic signed [A:0] d, input logic [14:0] t);
    logic [A:0] mag;
    mag = d[A] ? A'(0) - d : d;
    return CW'(mag) <= CW'(t);
  endfunction

  assign ji = in_data[2:0];
  assign jw = ji[JW-1:0];
  assign status.move = move_next;

  assign d_tm = (A+1)'(stg_t[jcnt]) - (A+1)'(stg_m[jcnt]);
  assign d_ta = (A+1)'(stg_t[jcnt]) - (A+1)'(applied[jcnt]);
  assign diff = (A+1)'(desired[jcnt]) - (A+1)'(applied[jcnt]);
  assign diffx = LW'(diff);
  assign limx  = signed'(LW'(lim));
  assign stepx = (diffx > limx) ? limx : ((diffx < -limx) ? -limx : diffx);
  assign step  = stepx[A:0];
  assign sum   = (A+1)'(applied[jcnt]) + step;
  assign rem   = diff - step;
  assign qf    = 45'(prod) * 45'(tjts_pkg::DIV_RECIP);
  assign d32   = ev_seq - recv_seq;

  always_comb begin
    mode_next        = mode;
    session_next     = session;
    have_seq_next    = have_seq;
    recv_next        = recv_seq;
    applied_seq_next = applied_seq;
    lct_next         = last_cmd_time;
    arm_p_next       = arm_pending;
    arm_seq_next     = arm_seq;
    final_p_next     = final_pending;
    final_seq_next   = final_seq;
    rej_next         = tjts_pkg::REJ_NONE;
    arm_next         = 1'b0;
    wseq_next        = '0;
    load_meas        = 1'b0;
    load_tgt         = 1'b0;
    hold_now         = 1'b0;
    move_next        = 1'b0;
    tick_upd         = 1'b0;
    dt_next          = tjts_pkg::DT_FIRST;
    if (ev_kind == tjts_pkg::KIND_COMMAND) begin
      if (ev_bad) begin
        rej_next = tjts_pkg::REJ_BAD;
      end else if (!ev_bus) begin
        rej_next       = tjts_pkg::REJ_BUS;
        mode_next      = tjts_pkg::MODE_FAULT;
        arm_p_next     = 1'b0;
        arm_seq_next   = '0;
        final_p_next   = 1'b0;
        final_seq_next = '0;
      end else begin
        if (mode_next == tjts_pkg::MODE_FAULT) begin
          mode_next     = tjts_pkg::MODE_WAIT;
          session_next  = '0;
          have_seq_next = 1'b0;
        end
        if (mode_next == tjts_pkg::MODE_ACTIVE && ev_sess == session_next &&
            !(!have_seq_next || (d32 != '0 && !d32[31]))) begin
          rej_next = tjts_pkg::REJ_STALE;
        end else begin
          if (mode_next == tjts_pkg::MODE_ACTIVE && ev_sess != session_next) begin
            mode_next      = tjts_pkg::MODE_WAIT;
            session_next   = '0;
            have_seq_next  = 1'b0;
            arm_p_next     = 1'b0;
            arm_seq_next   = '0;
            final_p_next   = 1'b0;
            final_seq_next = '0;
          end
          if (mode_next != tjts_pkg::MODE_ACTIVE) begin
            if (!near_tm) begin
              rej_next = tjts_pkg::REJ_HANDSHAKE;
            end else begin
              mode_next     = tjts_pkg::MODE_WAIT;
              session_next  = ev_sess;
              recv_next     = ev_seq;
              have_seq_next = 1'b1;
              lct_next      = ev_now;
              load_meas     = 1'b1;
              arm_p_next    = 1'b1;
              arm_seq_next  = ev_seq;
              arm_next      = 1'b1;
              wseq_next     = ev_seq;
            end
          end else begin
            session_next  = ev_sess;
            recv_next     = ev_seq;
            have_seq_next = 1'b1;
            lct_next      = ev_now;
            load_tgt      = 1'b1;
            if (near_ta) begin
              applied_seq_next = ev_seq;
            end
          end
        end
      end
    end else if (ev_kind == tjts_pkg::KIND_TICK) begin
      if (!ev_bus) begin
        if (mode == tjts_pkg::MODE_ACTIVE) begin
          mode_next      = tjts_pkg::MODE_FAULT;
          arm_p_next     = 1'b0;
          arm_seq_next   = '0;
          final_p_next   = 1'b0;
          final_seq_next = '0;
        end
        rej_next = tjts_pkg::REJ_BUS;
      end else if (mode == tjts_pkg::MODE_FAULT) begin
        mode_next      = tjts_pkg::MODE_WAIT;
        session_next   = '0;
        have_seq_next  = 1'b0;
        arm_p_next     = 1'b0;
        arm_seq_next   = '0;
        final_p_next   = 1'b0;
        final_seq_next = '0;
      end else if (mode == tjts_pkg::MODE_ACTIVE &&
                   (ev_now - last_cmd_time) > 32'(timeout)) begin
        mode_next      = tjts_pkg::MODE_HOLD;
        hold_now       = 1'b1;
        arm_p_next     = 1'b0;
        arm_seq_next   = '0;
        final_p_next   = 1'b0;
        final_seq_next = '0;
      end else if (mode == tjts_pkg::MODE_ACTIVE) begin
        if (have_tick) begin
          if (ev_now == last_tick_time) begin
            dt_next = tjts_pkg::DT_MIN;
          end else if ((ev_now - last_tick_time) > 32'(tjts_pkg::DT_MAX)) begin
            dt_next = tjts_pkg::DT_MAX;
          end else begin
            dt_next = 6'(ev_now - last_tick_time);
          end
        end
        tick_upd  = 1'b1;
        move_next = 1'b1;
        wseq_next = recv_seq;
      end
    end else begin
      if (!ev_wok) begin
        mode_next      = tjts_pkg::MODE_FAULT;
        arm_p_next     = 1'b0;
        arm_seq_next   = '0;
        final_p_next   = 1'b0;
        final_seq_next = '0;
      end else if (arm_pending) begin
        mode_next        = tjts_pkg::MODE_ACTIVE;
        applied_seq_next = arm_seq;
        arm_p_next       = 1'b0;
        arm_seq_next     = '0;
        final_p_next     = 1'b0;
        final_seq_next   = '0;
      end else if (final_pending) begin
        applied_seq_next = final_seq;
        final_p_next     = 1'b0;
        final_seq_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol     <= tjts_pkg::TOL_RESET;
      timeout <= tjts_pkg::TIMEOUT_RESET;
      for (int i = 0; i < tjts_pkg::VEL_REGS; i++) begin
        vel[i] <= tjts_pkg::VEL_RESET;
      end
    end else if (cfg_we) begin
      if (cfg_index == tjts_pkg::REG_TOLERANCE) begin
        tol <= cfg_data[14:0];
      end else if (cfg_index == tjts_pkg::REG_TIMEOUT) begin
        timeout <= cfg_data;
      end else begin
        vel[cfg_index - tjts_pkg::REG_VEL0] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stage && ji < 3'(JOINTS)) begin
      stg_t[jw] <= in_data[TG_LO +: A];
      stg_m[jw] <= in_data[ME_LO +: A];
    end
    if (cmd.latch) begin
      ev_kind <= kind;
      ev_sess <= in_data[SES_LO +: 32];
      ev_seq  <= in_data[SEQ_LO +: 32];
      ev_now  <= in_data[TIM_LO +: 32];
      ev_bus  <= in_data[BUS_B];
      ev_wok  <= in_data[WOK_B];
      ev_bad  <= staged_bad | in_data[BAD_B];
    end
    if (cmd.scan) begin
      near_tm <= (cmd.first | near_tm) & near_ok(d_tm, tol);
      near_ta <= (cmd.first | near_ta) & near_ok(d_ta, tol);
    end
    if (cmd.decide) begin
      rej  <= rej_next;
      arm  <= arm_next;
      wseq <= wseq_next;
      wr   <= 1'b0;
      fin  <= 1'b0;
      dt   <= dt_next;
    end
    if (cmd.mul) begin
      prod <= vel[jcnt] * dt;
    end
    if (cmd.div) begin
      lim <= qf[tjts_pkg::DIV_SHIFT +: 13];
    end
    if (cmd.step) begin
      wr  <= wr | (step != '0);
      fin <= (cmd.first | fin) & near_ok(rem, tol);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= tjts_pkg::MODE_WAIT;
      session        <= '0;
      have_seq       <= 1'b0;
      recv_seq       <= '0;
      applied_seq    <= '0;
      last_cmd_time  <= '0;
      arm_pending    <= 1'b0;
      arm_seq        <= '0;
      final_pending  <= 1'b0;
      final_seq      <= '0;
      have_tick      <= 1'b0;
      last_tick_time <= '0;
      staged_bad     <= 1'b0;
      for (int i = 0; i < JOINTS; i++) begin
        desired[i] <= '0;
        applied[i] <= '0;
      end
    end else begin
      if (cmd.latch) begin
        staged_bad <= 1'b0;
      end else if (cmd.stage && in_data[BAD_B]) begin
        staged_bad <= 1'b1;
      end
      if (cmd.decide) begin
        mode          <= mode_next;
        session       <= session_next;
        have_seq      <= have_seq_next;
        recv_seq      <= recv_next;
        applied_seq   <= applied_seq_next;
        last_cmd_time <= lct_next;
        arm_pending   <= arm_p_next;
        arm_seq       <= arm_seq_next;
        final_pending <= final_p_next;
        final_seq     <= final_seq_next;
        if (tick_upd) begin
          have_tick      <= 1'b1;
          last_tick_time <= ev_now;
        end
        for (int i = 0; i < JOINTS; i++) begin
          if (load_meas) begin
            desired[i] <= stg_m[i];
            applied[i] <= stg_m[i];
          end else if (load_tgt) begin
            desired[i] <= stg_t[i];
          end else if (hold_now) begin
            desired[i] <= applied[i];
          end
        end
      end
      if (cmd.step) begin
        applied[jcnt] <= sum[A-1:0];
      end
      if (cmd.fin) begin
        if (fin && wr) begin
          final_pending <= 1'b1;
          final_seq     <= recv_seq;
        end else begin
          final_pending <= 1'b0;
          final_seq     <= '0;
        end
      end
    end
  end

  assign out_data = OW'({applied[jcnt], 3'(jcnt), applied_seq, recv_seq, wseq,
                         fin, wr, arm, rej, mode});

endmodule

@@ design/teleop_joint_target_supervisor.sv @@
// Top level of the teleop joint target supervisor.
// Depends on tjts_pkg, tjts_ctrl and tjts_datapath.
//
//  channel  direction  handshake           payload
//  s_*      in         s_tvalid/s_tready   s_tdata, s_tlast, s_tuser
//  m_*      out        m_tvalid/m_tready   m_tdata, m_tlast
//  cfg_*    in         cfg_we              cfg_index, cfg_data
//
// A request that does not end an event is taken without a stall. A final
// request starts a scan of each joint and a decision; for an active tick
// each joint gets a multiply, reciprocal divide and step, plus a finish step,
// before JOINTS results are offered, one per cycle while m_tready is high.
// Reset is synchronous; configuration returns to its reset values.
// s_tready is low from the final request until the last result is taken.
module teleop_joint_target_supervisor #(
  parameter int JOINTS = 6,
  parameter int ANGLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // Fields from bit 0: joint_index, target_angle, measured_angle, target_bad,
  // session, sequence_number, time_ms, bus_ok, write_ok.
  input  logic [((102 + 2 * ANGLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic s_tlast,
  // Fields from bit 0: command.
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // Fields from bit 0: mode, reject_code, arm_request, write_request, at_final,
  // write_seq, received_seq, applied_seq, joint_out, applied_angle.
  output logic [((107 + ANGLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  output logic m_tlast,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int IW = ((102 + 2 * ANGLE_BITS + 7) / 8) * 8;
  localparam int OW = ((107 + ANGLE_BITS + 7) / 8) * 8;

  tjts_pkg::ctl_cmd_t   cmd;
  tjts_pkg::dp_status_t status;
  logic [JW-1:0]        jcnt;

  tjts_ctrl #(.JOINTS(JOINTS), .JW(JW)) u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
    .status(status), .cmd(cmd), .jcnt(jcnt)
  );

  tjts_datapath #(
    .JOINTS(JOINTS), .ANGLE_BITS(ANGLE_BITS), .JW(JW), .IW(IW), .OW(OW)
  ) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .jcnt(jcnt), .status(status),
    .kind(s_tuser), .in_data(s_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_data(m_tdata)
  );

endmodule
